[src/srp_pkg.sv]
// Shared types, constants and codes of the shelf rectangle packer.
`default_nettype none

package srp_pkg;

  // Page count and largest usable page side.
  localparam int unsigned SrpMaxPages = 16;
  localparam int unsigned SideW       = 13;
  localparam int unsigned RectW       = 12;
  localparam logic [SideW-1:0] MaxSide   = 13'd4096;
  localparam logic [SideW-1:0] SideReset = 13'd1024;
  localparam logic [SideW-1:0] Pad       = 13'd1;

  // Configuration register indexes (byte address bit 2).
  localparam logic RegPageWidth  = 1'b0;
  localparam logic RegPageHeight = 1'b1;

  typedef enum logic {
    OpPlace  = 1'b0,
    OpRewind = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StPlaced = 2'd0,
    StNoFit  = 2'd1,
    StRewind = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SIdle,
    SScan,
    SFresh,
    SResp
  } state_e;

  // Cursor state of one page.
  typedef struct packed {
    logic [SideW-1:0] cursor_x;
    logic [SideW-1:0] cursor_y;
    logic [RectW-1:0] row_height;
  } entry_t;

  localparam entry_t EntryReset = '{cursor_x: Pad, cursor_y: Pad, row_height: '0};

  typedef struct packed {
    logic             operation;
    logic [RectW-1:0] rect_width;
    logic [RectW-1:0] rect_height;
  } srp_in_t;

  typedef struct packed {
    status_e          status;
    logic [3:0]       page_index;
    logic [RectW-1:0] place_x;
    logic [RectW-1:0] place_y;
    logic [15:0]      version;
  } srp_out_t;

  // Outcome of trying one page.
  typedef struct packed {
    logic             fit;
    logic [SideW-1:0] pos_x;
    logic [SideW-1:0] pos_y;
  } fit_res_t;

endpackage

`default_nettype wire

[src/srp_page_mem.sv]
// Page cursor memory with one registered read port and per-entry valid bits.
`default_nettype none

module srp_page_mem #(
  parameter int unsigned MaxPages = srp_pkg::SrpMaxPages,
  parameter int unsigned IdxW     = (MaxPages > 1) ? $clog2(MaxPages) : 1
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 clr_i,
  input  wire                 we_i,
  input  wire  [IdxW-1:0]     waddr_i,
  input  srp_pkg::entry_t     wdata_i,
  input  wire  [IdxW-1:0]     raddr_i,
  output srp_pkg::entry_t     rdata_o
);
  import srp_pkg::*;

  entry_t               mem_q [MaxPages];
  logic [MaxPages-1:0]  vld_q;
  entry_t               rd_data_q;
  logic                 rd_vld_q;

  // Storage array: one write port, one registered read port with write forwarding.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rd_data_q <= wdata_i;
    end else begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  // Valid bits: an entry never written since reset or rewind reads as a fresh page.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
      if (clr_i) begin
        rd_vld_q <= 1'b0;
      end else if (we_i && (waddr_i == raddr_i)) begin
        rd_vld_q <= 1'b1;
      end else begin
        rd_vld_q <= vld_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : EntryReset;

endmodule

`default_nettype wire

[src/srp_fit.sv]
// Shelf placement check of one page and its updated cursor.
`default_nettype none

module srp_fit (
  input  srp_pkg::entry_t                 entry_i,
  input  wire  [srp_pkg::RectW-1:0]       rect_w_i,
  input  wire  [srp_pkg::RectW-1:0]       rect_h_i,
  input  wire  [srp_pkg::SideW-1:0]       page_w_i,
  input  wire  [srp_pkg::SideW-1:0]       page_h_i,
  output srp_pkg::fit_res_t               res_o,
  output srp_pkg::entry_t                 entry_o
);
  import srp_pkg::*;

  localparam int unsigned SumW = SideW + 2;

  logic [SumW-1:0] right_edge;
  logic            wrap;
  logic [SumW-1:0] x_sel;
  logic [SumW-1:0] y_sel;
  logic [RectW-1:0] rh_sel;
  logic [SumW-1:0] bottom_edge;
  logic [SumW-1:0] next_x;

  always_comb begin
    // Wrap to a new shelf when the rectangle plus padding passes the right edge.
    right_edge = SumW'(entry_i.cursor_x) + SumW'(rect_w_i) + SumW'(Pad);
    wrap       = right_edge > SumW'(page_w_i);
    if (wrap) begin
      x_sel  = '0;
      y_sel  = SumW'(entry_i.cursor_y) + SumW'(entry_i.row_height) + SumW'(Pad);
      rh_sel = '0;
    end else begin
      x_sel  = SumW'(entry_i.cursor_x);
      y_sel  = SumW'(entry_i.cursor_y);
      rh_sel = entry_i.row_height;
    end

    // The page refuses when the rectangle passes the bottom edge.
    bottom_edge = y_sel + SumW'(rect_h_i);
    res_o.fit   = bottom_edge <= SumW'(page_h_i);
    res_o.pos_x = x_sel[SideW-1:0];
    res_o.pos_y = y_sel[SideW-1:0];

    next_x              = x_sel + SumW'(rect_w_i) + SumW'(Pad);
    entry_o.cursor_x    = next_x[SideW-1:0];
    entry_o.cursor_y    = y_sel[SideW-1:0];
    entry_o.row_height  = (rh_sel < rect_h_i) ? rect_h_i : rh_sel;
  end

endmodule

`default_nettype wire

[src/shelf_rect_packer_multi_page.sv]
// Top level of the multi-page shelf rectangle packer.
//
// Requests enter on in_valid_i / in_data_i and are taken when in_stall_o is
// low; one result per request leaves on out_valid_o / out_data_o and is taken
// when out_stall_i is low. Page size lives in the APB registers page_width
// (address 0) and page_height (address 4); the user is to set it only while
// the block is idle, which the block itself does not enforce.
//
// A place request reads the page cursors one page per cycle from the cursor
// memory (one read port), in first-fit order; when no page in use takes the
// rectangle and fewer than MAX_PAGES pages are in use, a fresh page is opened.
// The result is written to a result register and moves from there into the
// output register once that register is free; a rewind takes the same path.
// The block returns to idle as the result moves into the output register and
// only then takes the next request, so one request is in work at a time.
//
// Reset puts every page at cursor (1,1), one page in use, the version at 0
// and both sides at 1024 pixels; it takes effect at once. When the receiver
// stalls, a finished result waits in the output register and the next
// result waits inside the block, which then holds off new requests.
`default_nettype none

module shelf_rect_packer_multi_page #(
  parameter int unsigned MAX_PAGES = srp_pkg::SrpMaxPages
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  srp_pkg::srp_in_t   in_data_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output srp_pkg::srp_out_t  out_data_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import srp_pkg::*;

  localparam int unsigned IdxW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CntW = $clog2(MAX_PAGES + 1);

  state_e           state_q, state_d;
  logic [IdxW-1:0]  scan_q, scan_d;
  logic [RectW-1:0] w_q, w_d, h_q, h_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [15:0]      version_q, version_d;
  srp_out_t         res_q, res_d;
  logic             out_valid_q, out_valid_d;
  srp_out_t         out_data_q, out_data_d;
  logic [SideW-1:0] pw_q, ph_q;
  logic [SideW-1:0] pw_eff, ph_eff;

  logic             accept;
  logic             cfg_we;
  logic             mem_clr, mem_we;
  logic [IdxW-1:0]  mem_waddr;
  entry_t           mem_rdata;
  entry_t           fit_in, fit_entry;
  fit_res_t         fit_res;
  logic [IdxW-1:0]  cur_page;
  logic [IdxW+3:0]  page_wide;
  logic [CntW-1:0]  scan_next;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= SideReset;
      ph_q <= SideReset;
    end else if (cfg_we) begin
      unique case (paddr[2])
        RegPageWidth:  pw_q <= pwdata[SideW-1:0];
        RegPageHeight: ph_q <= pwdata[SideW-1:0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegPageWidth:  prdata = {{(32-SideW){1'b0}}, pw_q};
      RegPageHeight: prdata = {{(32-SideW){1'b0}}, ph_q};
      default:       prdata = '0;
    endcase
  end

  // Sides above the largest supported page are used as that size.
  assign pw_eff = (pw_q > MaxSide) ? MaxSide : pw_q;
  assign ph_eff = (ph_q > MaxSide) ? MaxSide : ph_q;

  // Cursor memory and the placement check it feeds.
  srp_page_mem #(
    .MaxPages (MAX_PAGES),
    .IdxW     (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (mem_clr),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (fit_entry),
    .raddr_i (scan_d),
    .rdata_o (mem_rdata)
  );

  assign fit_in   = (state_q == SFresh) ? EntryReset : mem_rdata;
  assign cur_page = (state_q == SFresh) ? IdxW'(used_q) : scan_q;

  srp_fit u_fit (
    .entry_i  (fit_in),
    .rect_w_i (w_q),
    .rect_h_i (h_q),
    .page_w_i (pw_eff),
    .page_h_i (ph_eff),
    .res_o    (fit_res),
    .entry_o  (fit_entry)
  );

  // Requests are taken only while the sequencer is idle.
  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign page_wide  = {4'b0000, cur_page};
  assign scan_next  = CntW'(scan_q) + CntW'(1);

  // Request sequencer: scan pages in order, then try a fresh page.
  always_comb begin
    state_d     = state_q;
    scan_d      = scan_q;
    w_d         = w_q;
    h_d         = h_q;
    used_d      = used_q;
    version_d   = version_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    mem_clr     = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_page;

    unique case (state_q)
      SIdle: begin
        scan_d     = '0;
        if (accept) begin
          w_d = in_data_i.rect_width;
          h_d = in_data_i.rect_height;
          if (in_data_i.operation == OpRewind) begin
            mem_clr   = 1'b1;
            version_d = version_q + 16'd1;
            res_d     = '{status: StRewind, page_index: '0, place_x: '0,
                          place_y: '0, version: version_q + 16'd1};
            state_d   = SResp;
          end else begin
            state_d = SScan;
          end
        end
      end

      SScan, SFresh: begin
        if (fit_res.fit) begin
          mem_we  = 1'b1;
          res_d   = '{status: StPlaced, page_index: page_wide[3:0],
                      place_x: fit_res.pos_x[RectW-1:0],
                      place_y: fit_res.pos_y[RectW-1:0], version: version_q};
          state_d = SResp;
          if (state_q == SFresh) begin
            used_d = used_q + CntW'(1);
          end
        end else if ((state_q == SScan) && (scan_next < used_q)) begin
          scan_d = IdxW'(scan_next);
        end else if ((state_q == SScan) && (used_q < CntW'(MAX_PAGES))) begin
          state_d = SFresh;
        end else begin
          res_d   = '{status: StNoFit, page_index: '0, place_x: '0,
                      place_y: '0, version: version_q};
          state_d = SResp;
        end
      end

      SResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_data_d  = res_q;
          state_d     = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      scan_q      <= '0;
      used_q      <= CntW'(1);
      version_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      used_q      <= used_d;
      version_q   <= version_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    w_q        <= w_d;
    h_q        <= h_d;
    res_q      <= res_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

[src/srp_checker.sv]
// Port-level checks of the shelf rectangle packer, bound to its top level.
`default_nettype none

module srp_checker (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_stall_o,
  input wire                out_valid_o,
  input wire                out_stall_i,
  input srp_pkg::srp_out_t  out_data_o
);
  import srp_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken while one is in work");

  // A result that places nothing carries no position.
  a_no_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != StPlaced) |->
      (out_data_o.page_index == 4'd0) && (out_data_o.place_x == '0) &&
      (out_data_o.place_y == '0))
    else $error("position reported without a placement");

endmodule

bind shelf_rect_packer_multi_page srp_checker u_srp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
